FILE: rtl/core/sfdl_pkg.sv
// shared constants and types for the stereo feedback delay with lowpass damping
package sfdl_pkg;

  // register field widths
  localparam int DELAY_W    = 13;
  localparam int FB_W       = 15;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX = 3'd3;

  // register values after reset
  localparam logic [DELAY_W-1:0] DELAY_RST   = 13'd2880;
  localparam logic [FB_W-1:0]    FB_GAIN_RST = 15'd3277;
  localparam logic [COEF_W-1:0]  LP_COEF_RST = 16'd13357;
  localparam logic [COEF_W-1:0]  WET_MIX_RST = 16'd16384;

  // coefficient limits, q1.15
  localparam logic [FB_W-1:0]   FEEDBACK_MAX = 15'd16384;
  localparam logic [COEF_W-1:0] UNITY_Q15    = 16'd32768;
  localparam int                COEF_SHIFT   = 15;

  // largest delay register value
  localparam int DELAY_MAX = 8191;

  // delay reduction step counter
  localparam int RED_CNT_W = 4;

  // multiply schedule of the shared unit
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_LP_L  = 3'd0;
  localparam logic [OP_W-1:0] OP_LP_R  = 3'd1;
  localparam logic [OP_W-1:0] OP_MIX_L = 3'd2;
  localparam logic [OP_W-1:0] OP_MIX_R = 3'd3;
  localparam logic [OP_W-1:0] OP_FB_L  = 3'd4;
  localparam logic [OP_W-1:0] OP_FB_R  = 3'd5;
  localparam logic [OP_W-1:0] OP_DRAIN = 3'd6;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RED   = 6'b000010,
    ST_READ  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

FILE: rtl/core/sfdl_in_if.sv
// input channel: one stereo sample pair per word
interface sfdl_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

FILE: rtl/core/sfdl_out_if.sv
// output channel: one mixed stereo sample pair per word
interface sfdl_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

FILE: rtl/core/stereo_feedback_delay_lowpass_top.sv
// stereo feedback delay with one-pole lowpass damping, one shared multiplier
// an accepted word passes ST_RED (skipped when RED_STEPS is 0, as at 8192 deep),
// ST_READ, ST_MUL (six multiplies in turn on the single shared multiplier), ST_WRITE
//   and ST_FIN, waiting there for the output; a new word is taken only in ST_IDLE
// RED_STEPS is the number of restoring steps that fold the delay into the depth
// reset: registers take their defaults, delay lines read as zero through a fill count
module stereo_feedback_delay_lowpass_top
  import sfdl_pkg::*;
#(
  parameter int DELAY_DEPTH = 8192,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfdl_in_if.sink               in_i,
  sfdl_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int CW  = AW + 1;
  localparam int RSW = AW + 1;
  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = SB + 18;
  localparam int AW2 = SB + 4;

  localparam logic signed [AW2-1:0] SAT_HI =
    AW2'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW2-1:0] SAT_LO = -SAT_HI - AW2'(1);

  // number of restoring steps that bring a delay value below the depth
  function automatic int red_steps_f(input int depth);
    int n;
    n = 0;
    for (int s = 0; s < DELAY_W; s++) begin
      if ((depth << s) <= DELAY_MAX) n = s + 1;
    end
    return n;
  endfunction

  localparam int RED_STEPS = red_steps_f(DELAY_DEPTH);

  function automatic logic signed [SB-1:0] sat_f(input logic signed [AW2-1:0] x);
    logic signed [AW2-1:0] y;
    y = x;
    if (x > SAT_HI) y = SAT_HI;
    if (x < SAT_LO) y = SAT_LO;
    return y[SB-1:0];
  endfunction

  state_e state_q, state_d;

  logic [DELAY_W-1:0]   dly_q;
  logic [FB_W-1:0]      fb_q;
  logic [COEF_W-1:0]    lpc_q;
  logic [COEF_W-1:0]    wet_q;
  logic [FB_W-1:0]      fb_c;
  logic [COEF_W-1:0]    lpc_c;
  logic [COEF_W-1:0]    wet_c;

  logic [DELAY_W-1:0]   dred_q;
  logic [RED_CNT_W-1:0] red_cnt_q;
  logic [31:0]          red_sub;
  logic [AW-1:0]        wp_q;
  logic [CW-1:0]        fill_q;
  logic [RSW-1:0]       rd_sum;
  logic [AW-1:0]        rd_addr;
  logic                 hit_q;
  logic [OP_W-1:0]      cnt_q;
  logic [OP_W-1:0]      op_prev_q;
  logic                 post_en;
  logic                 post_r;
  logic                 in_acc;
  logic                 out_load;

  logic signed [SB-1:0] in_l_q, in_r_q;
  logic signed [SB-1:0] lp_l_q, lp_r_q;
  logic signed [SB-1:0] w_l_q, w_r_q;
  logic signed [SB-1:0] res_l_q, res_r_q;
  logic signed [SB-1:0] rdata_l_q, rdata_r_q;
  logic signed [SB-1:0] del_l, del_r;
  logic signed [SB-1:0] out_l_q, out_r_q;
  logic                 out_vld_q;

  logic signed [SB-1:0] mem_l [DELAY_DEPTH];
  logic signed [SB-1:0] mem_r [DELAY_DEPTH];

  logic signed [SB:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [PW-1:0]  prod_q;
  logic signed [PW-1:0]  prod_sh;
  logic signed [PW:0]    mix_sum;
  logic signed [PW:0]    mix_sh;
  logic signed [SB-1:0]  lp_sel, in_sel;
  logic signed [AW2-1:0] acc_lp, acc_fb, acc_mix;

  // handshakes
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_FIN) && (!out_vld_q || out_o.ready);
  assign out_o.valid     = out_vld_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

  // coefficient limits
  assign fb_c  = (fb_q > FEEDBACK_MAX) ? FEEDBACK_MAX : fb_q;
  assign lpc_c = (lpc_q > UNITY_Q15) ? UNITY_Q15 : lpc_q;
  assign wet_c = (wet_q > UNITY_Q15) ? UNITY_Q15 : wet_q;

  // restoring step of the delay fold
  assign red_sub = 32'(dred_q) - 32'(DELAY_DEPTH << red_cnt_q);

  // read address: delay behind the write position, wrapped into the ring
  assign rd_sum  = RSW'(wp_q) + RSW'(DELAY_DEPTH) - RSW'(dred_q);
  assign rd_addr = (rd_sum >= RSW'(DELAY_DEPTH)) ? AW'(rd_sum - RSW'(DELAY_DEPTH))
                                                  : AW'(rd_sum);

  // entries never written read as zero
  assign del_l = hit_q ? rdata_l_q : '0;
  assign del_r = hit_q ? rdata_r_q : '0;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = (RED_STEPS == 0) ? ST_READ : ST_RED;
      end
      ST_RED: begin
        if (red_cnt_q == '0) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == OP_DRAIN) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = ST_FIN;
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      red_cnt_q <= '0;
      cnt_q     <= OP_LP_L;
      wp_q      <= '0;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
      dly_q     <= DELAY_RST;
      fb_q      <= FB_GAIN_RST;
      lpc_q     <= LP_COEF_RST;
      wet_q     <= WET_MIX_RST;
    end else begin
      state_q <= state_d;
      if (in_acc) red_cnt_q <= RED_CNT_W'(RED_STEPS - 1);
      else if (state_q == ST_RED) red_cnt_q <= red_cnt_q - RED_CNT_W'(1);
      if (state_q == ST_MUL) cnt_q <= cnt_q + OP_W'(1);
      else cnt_q <= OP_LP_L;
      if (state_q == ST_WRITE) begin
        wp_q <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        if (fill_q != CW'(DELAY_DEPTH)) fill_q <= fill_q + CW'(1);
      end
      if (out_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DELAY:   dly_q <= cfg_data_i[DELAY_W-1:0];
          CFG_FB_GAIN: fb_q  <= cfg_data_i[FB_W-1:0];
          CFG_LP_COEF: lpc_q <= cfg_data_i[COEF_W-1:0];
          CFG_WET_MIX: wet_q <= cfg_data_i[COEF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cnt_q)
      OP_LP_L: begin
        mul_a = (SB+1)'(del_l) - (SB+1)'(lp_l_q);
        mul_b = signed'({1'b0, lpc_c});
      end
      OP_LP_R: begin
        mul_a = (SB+1)'(del_r) - (SB+1)'(lp_r_q);
        mul_b = signed'({1'b0, lpc_c});
      end
      OP_MIX_L: begin
        mul_a = (SB+1)'(del_l) - (SB+1)'(in_l_q);
        mul_b = signed'({1'b0, wet_c});
      end
      OP_MIX_R: begin
        mul_a = (SB+1)'(del_r) - (SB+1)'(in_r_q);
        mul_b = signed'({1'b0, wet_c});
      end
      OP_FB_L: begin
        mul_a = (SB+1)'(lp_l_q);
        mul_b = signed'({2'b00, fb_c});
      end
      OP_FB_R: begin
        mul_a = (SB+1)'(lp_r_q);
        mul_b = signed'({2'b00, fb_c});
      end
      default: ;
    endcase
  end

  // post-processing of the registered product, in the cycle after its multiply
  assign post_en = (state_q == ST_MUL) && (cnt_q != OP_LP_L);
  assign post_r  = op_prev_q[0];
  assign lp_sel  = post_r ? lp_r_q : lp_l_q;
  assign in_sel  = post_r ? in_r_q : in_l_q;
  assign prod_sh = prod_q >>> COEF_SHIFT;
  assign acc_lp  = AW2'(lp_sel) + AW2'(prod_sh);
  assign acc_fb  = AW2'(in_sel) + AW2'(prod_sh);
  assign mix_sum = ((PW+1)'(in_sel) <<< COEF_SHIFT) + (PW+1)'(prod_q);
  assign mix_sh  = mix_sum >>> COEF_SHIFT;
  assign acc_mix = AW2'(mix_sh);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_l_q <= in_i.left_in;
      in_r_q <= in_i.right_in;
      dred_q <= dly_q;
    end else if (state_q == ST_RED && dred_q >= DELAY_W'(DELAY_DEPTH << red_cnt_q)
                 && (DELAY_DEPTH << red_cnt_q) <= DELAY_MAX) begin
      dred_q <= DELAY_W'(red_sub);
    end
    if (state_q == ST_READ) hit_q <= (CW'(rd_addr) < fill_q);
    prod_q    <= mul_a * mul_b;
    op_prev_q <= cnt_q;
    if (post_en) begin
      case (op_prev_q)
        OP_MIX_L: res_l_q <= sat_f(acc_mix);
        OP_MIX_R: res_r_q <= sat_f(acc_mix);
        OP_FB_L:  w_l_q   <= sat_f(acc_fb);
        OP_FB_R:  w_r_q   <= sat_f(acc_fb);
        default: ;
      endcase
    end
    if (out_load) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  // lowpass states reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_l_q <= '0;
      lp_r_q <= '0;
    end else if (post_en) begin
      if (op_prev_q == OP_LP_L) lp_l_q <= sat_f(acc_lp);
      if (op_prev_q == OP_LP_R) lp_r_q <= sat_f(acc_lp);
    end
  end

  // left delay line
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) mem_l[wp_q] <= w_l_q;
    if (state_q == ST_READ) rdata_l_q <= mem_l[rd_addr];
  end

  // right delay line
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) mem_r[wp_q] <= w_r_q;
    if (state_q == ST_READ) rdata_r_q <= mem_r[rd_addr];
  end

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DELAY_DEPTH))
    else $error("fill count beyond depth");

  a_fill_tracks_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != CW'(DELAY_DEPTH)) |-> (fill_q == CW'(wp_q)))
    else $error("fill count lost track of write position");

  a_delay_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (32'(dred_q) < 32'(DELAY_DEPTH)))
    else $error("delay not folded below depth before read");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again while word in progress");

endmodule

FILE: tb/sfdl_tb_pkg.sv
// scoreboard class for the stereo feedback delay: predicts and checks output words
`timescale 1ns / 1ps
package sfdl_tb_pkg;
  import sfdl_pkg::*;

  localparam int LINE_DEPTH = 8192;
  localparam int SAMPLE_W   = 24;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_word_t;

  class echo_tracker;
    logic [SAMPLE_W-1:0] delay_line [2][LINE_DEPTH];
    longint              lp_state   [2];
    logic [DELAY_W-1:0]  wr_pos;
    logic [DELAY_W-1:0]  delay_len;
    logic [FB_W-1:0]     fb_gain;
    logic [COEF_W-1:0]   lp_coef;
    logic [COEF_W-1:0]   wet;
    stereo_word_t        pending_pairs[$];
    int unsigned         mismatches;

    function new();
      foreach (delay_line[c, i]) delay_line[c][i] = '0;
      lp_state[0] = 0;
      lp_state[1] = 0;
      wr_pos      = '0;
      delay_len   = DELAY_RST;
      fb_gain     = FB_GAIN_RST;
      lp_coef     = LP_COEF_RST;
      wet         = WET_MIX_RST;
      mismatches  = 0;
    endfunction

    // register write as the block sees it, spare indexes dropped
    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DELAY:   delay_len = data[DELAY_W-1:0];
        CFG_FB_GAIN: fb_gain   = data[FB_W-1:0];
        CFG_LP_COEF: lp_coef   = data;
        CFG_WET_MIX: wet       = data;
        default: ;
      endcase
    endfunction

    // saturate to the signed sample range
    static function longint clip24(longint x);
      longint hi;
      longint lo;
      hi = 64'sd8388607;
      lo = -64'sd8388608;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    // one channel: damp the tap, write back the feedback, return the crossfade
    function logic signed [SAMPLE_W-1:0] damp_channel(int ch, logic [DELAY_W-1:0] rd,
                                                      logic signed [SAMPLE_W-1:0] x);
      longint dry, tap, fb, lc, wm, unity, fed, mix;
      logic [SAMPLE_W-1:0] tap_raw;
      unity   = UNITY_Q15;
      dry     = x;
      tap_raw = delay_line[ch][rd];
      tap     = longint'(signed'(tap_raw));
      fb      = (fb_gain > FEEDBACK_MAX) ? longint'(FEEDBACK_MAX) : longint'(fb_gain);
      lc      = (lp_coef > UNITY_Q15) ? unity : longint'(lp_coef);
      wm      = (wet > UNITY_Q15) ? unity : longint'(wet);
      lp_state[ch] = clip24(lp_state[ch] + ((lc * (tap - lp_state[ch])) >>> COEF_SHIFT));
      fed = clip24(dry + ((lp_state[ch] * fb) >>> COEF_SHIFT));
      delay_line[ch][wr_pos] = fed[SAMPLE_W-1:0];
      mix = clip24((dry * (unity - wm) + tap * wm) >>> COEF_SHIFT);
      return mix[SAMPLE_W-1:0];
    endfunction

    // accepted input word: work out the output word it causes
    function void take_input(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      logic [DELAY_W-1:0] rd;
      stereo_word_t       w;
      rd      = wr_pos - delay_len;
      w.left  = damp_channel(0, rd, l);
      w.right = damp_channel(1, rd, r);
      pending_pairs.push_back(w);
      wr_pos  = wr_pos + 1'b1;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // accepted output word against the oldest expectation
    function void match_output(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      stereo_word_t w;
      if (pending_pairs.size() == 0) begin
        flag($sformatf("output word with nothing expected: left %0d right %0d", l, r));
        return;
      end
      w = pending_pairs.pop_front();
      if (l !== w.left)
        flag($sformatf("left_out mismatch: expected %0d, got %0d", w.left, l));
      if (r !== w.right)
        flag($sformatf("right_out mismatch: expected %0d, got %0d", w.right, r));
    endfunction

    function int pending();
      return pending_pairs.size();
    endfunction
  endclass

endpackage

FILE: tb/stereo_feedback_delay_lowpass_top_test.sv
// testbench top for the stereo feedback delay with lowpass damping
`timescale 1ns / 1ps
module stereo_feedback_delay_lowpass_top_test;
  import sfdl_pkg::*;
  import sfdl_tb_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RAND_PHASES = 12;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam longint TIMEOUT_NS = 64'd6_000_000;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit quiet;
  int rx_hold;

  echo_tracker sb;

  sfdl_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  sfdl_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_if ();

  stereo_feedback_delay_lowpass_top DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("** stereo_feedback_delay_lowpass_top: FAILED **");
    $finish;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return SAMPLE_W'($urandom_range(0, 255) - 128);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // output side: random stalls, long hold-off on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
        repeat (n) begin
          @(negedge clk);
          out_if.ready <= 1'b0;
        end
      end else if (quiet) begin
        @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        n = pick_gap();
        repeat (n) begin
          @(negedge clk);
          out_if.ready <= 1'b0;
        end
        @(negedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  // check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.match_output(out_if.left_out, out_if.right_out);
  end

  // offer one word, after a random gap unless quiet
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.left_in  <= l;
    in_if.right_in <= r;
    do @(posedge clk); while (!in_if.ready);
    sb.take_input(l, r);
  endtask

  // stop offering and wait for every expected word
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.load_reg(idx, data);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] dly, input logic [CFG_DATA_W-1:0] fb,
                          input logic [CFG_DATA_W-1:0] lc, input logic [CFG_DATA_W-1:0] wm);
    write_reg(CFG_DELAY, dly);
    write_reg(CFG_FB_GAIN, fb);
    write_reg(CFG_LP_COEF, lc);
    write_reg(CFG_WET_MIX, wm);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random setting, extremes included
  task automatic random_regs();
    logic [CFG_DATA_W-1:0] dly, fb, lc, wm;
    case ($urandom_range(0, 7))
      0: dly = '0;
      1: dly = CFG_DATA_W'($urandom());
      2: dly = CFG_DATA_W'($urandom_range(1000, DELAY_MAX));
      default: dly = CFG_DATA_W'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 5))
      0: fb = '0;
      1: fb = CFG_DATA_W'(FEEDBACK_MAX);
      2: fb = CFG_DATA_W'($urandom());
      default: fb = CFG_DATA_W'($urandom_range(8000, FEEDBACK_MAX));
    endcase
    case ($urandom_range(0, 5))
      0: lc = '0;
      1: lc = UNITY_Q15;
      2: lc = CFG_DATA_W'($urandom());
      default: lc = CFG_DATA_W'($urandom_range(1000, UNITY_Q15));
    endcase
    case ($urandom_range(0, 5))
      0: wm = '0;
      1: wm = UNITY_Q15;
      2: wm = CFG_DATA_W'($urandom());
      default: wm = CFG_DATA_W'($urandom_range(0, UNITY_Q15));
    endcase
    set_regs(dly, fb, lc, wm);
  endtask

  // main sequence
  initial begin
    int n;
    sb             = new();
    quiet          = 1'b0;
    rx_hold        = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_DELAY;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.left_in  = '0;
    in_if.right_in = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: field extremes and bit patterns
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '0);
    send_pair(-24'sd1, 24'sd1);
    send_pair(24'sh555555, -24'sh555556);
    send_pair(-24'sh555556, 24'sh555555);
    drain();

    // shortest delay, gains above their limits, spare indexes ignored
    for (int i = CFG_WET_MIX + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom()));
    set_regs(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (4) send_pair(S_MAX, S_MIN);
    repeat (4) send_pair(S_MIN, S_MAX);
    drain();

    // delay field truncated, feedback clamped, lowpass frozen, fully dry
    set_regs(16'hE003, 16'h7FFF, '0, '0);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(24'sd12345, -24'sd12345);
    send_pair(S_MAX, S_MIN);
    send_pair('0, -24'sd1);
    drain();

    // zero delay reads a full line behind, unity coefficients
    set_regs('0, '0, UNITY_Q15, UNITY_Q15);
    repeat (4) send_pair(pick_sample(), pick_sample());
    drain();

    // random settings with random words
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_regs();
      quiet = (p == 3);
      n = $urandom_range(80, 120);
      if (p == 6) begin
        // long receiver hold-off while the sender keeps offering
        rx_hold = HOLD_CYCLES;
        quiet   = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
        if (p == 6 && k == 30) quiet = 1'b0;
        send_pair(pick_sample(), pick_sample());
      end
      drain();
      quiet = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** stereo_feedback_delay_lowpass_top: PASSED **");
    end else begin
      $display("** stereo_feedback_delay_lowpass_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sfdl_pkg.sv
rtl/core/sfdl_in_if.sv
rtl/core/sfdl_out_if.sv
rtl/core/stereo_feedback_delay_lowpass_top.sv
tb/sfdl_tb_pkg.sv
tb/stereo_feedback_delay_lowpass_top_test.sv
